>>> rtl/three_term_recurrence_checksum_top_macros.svh
// Assertion macros for the checksum block.
// Both sample on the rising edge of clock and are off while reset is high.
`ifndef THREE_TERM_RECURRENCE_CHECKSUM_TOP_MACROS_SVH
`define THREE_TERM_RECURRENCE_CHECKSUM_TOP_MACROS_SVH

// The condition must hold at every sampled edge.
`define TTRC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// If the trigger holds at one edge, the outcome must hold at the next edge.
`define TTRC_ASSERT_NEXT(lbl, trig, outcome, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (outcome)) \
      else $error(msg);

`endif

>>> rtl/ttrc_pkg.sv
`default_nettype none

package ttrc_pkg;

   localparam int ByteW = 8;
   localparam int TermW = 16;
   localparam int PosW  = 8;

   // Recurrence constants
   localparam logic [TermW-1:0] Modulus     = 16'hFFFF;
   localparam logic [TermW-1:0] FirstOffset = 16'd7;
   localparam logic [TermW-1:0] TermOne     = 16'd1;
   localparam logic [PosW-1:0]  PosOne      = 8'd1;

   // Datapath widths: factor = byte + alpha, products and signed difference
   localparam int FactorW = ByteW + 1;
   localparam int ProdW   = FactorW + TermW;
   localparam int SubW    = ByteW + TermW;
   localparam int DiffW   = ProdW + 1;
   localparam int HiW     = DiffW - TermW;

   // Multiple of the modulus that lifts any negative difference above zero
   localparam logic [DiffW-1:0] LiftBias = DiffW'(256 * 65535);

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             first_byte;
      logic             last_byte;
   } req_item_type;

endpackage

`default_nettype wire

>>> rtl/ttrc_req_if.sv
`default_nettype none

interface ttrc_req_if;
   import ttrc_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] data_byte;
   logic             first_byte;
   logic             last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ttrc_rsp_if.sv
`default_nettype none

interface ttrc_rsp_if;
   import ttrc_pkg::*;

   logic             valid;
   logic             ready;
   logic [TermW-1:0] checksum;

   modport source (output valid, output checksum, input ready);
   modport sink   (input valid, input checksum, output ready);
endinterface

`default_nettype wire

>>> rtl/ttrc_step.sv
`default_nettype none

module ttrc_step import ttrc_pkg::*; (
   input  wire logic [ByteW-1:0] data_byte,
   input  wire logic [PosW-1:0]  position,
   input  wire logic [TermW-1:0] older_term,
   input  wire logic [TermW-1:0] newer_term,
   output logic      [TermW-1:0] next_term
);

   logic [PosW-1:0]    alpha;
   logic [PosW-1:0]    beta;
   logic [FactorW-1:0] factor;
   logic [ProdW-1:0]   prod;
   logic [SubW-1:0]    sub;
   logic [DiffW-1:0]   diff;
   logic [DiffW-1:0]   lifted;
   logic [TermW:0]     folded;

   // alpha = 17*pos, beta = 31*pos, both mod 256, by shift and add
   assign alpha = position + {position[PosW-5:0], 4'b0000};
   assign beta  = {position[PosW-6:0], 5'b00000} - position;

   assign factor = FactorW'(data_byte) + FactorW'(alpha);
   assign prod   = factor * newer_term;
   assign sub    = beta * older_term;

   // Two's complement difference; a negative one takes one extra count,
   // since the wrap at 2^64 is 1 mod 65535
   assign diff   = DiffW'(prod) - DiffW'(sub);
   assign lifted = diff + DiffW'(diff[DiffW-1]) + LiftBias;

   // 2^16 = 1 mod 65535: fold high part onto low part, then one correction
   assign folded = (TermW+1)'(lifted[DiffW-1:TermW]) + (TermW+1)'(lifted[TermW-1:0]);

   always_comb begin
      if (folded >= (TermW+1)'(Modulus)) begin
         next_term = TermW'(folded - (TermW+1)'(Modulus));
      end else begin
         next_term = folded[TermW-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/three_term_recurrence_checksum_top.sv
// Three-term recurrence checksum over a byte stream.
//
// req channel: one message byte per item, with first_byte marking the start
// of a message and last_byte marking its end. rsp channel: one checksum item
// for every byte that carries last_byte; other bytes give no item.
// An accepted item is held in the input register, where the recurrence step
// (two narrow multiplies, a subtract and a fold modulo 65535) runs; as the
// byte leaves, its result goes into the recurrence state and, for a last
// byte, into the output register that drives rsp.valid. Throughput is one
// byte per cycle while no last byte waits in the input register; the
// recurrence state is updated in the same cycle the step is computed, so
// consecutive bytes chain without gaps. When the receiver stalls, a
// finished checksum waits in the output register and the input register
// still drains bytes that carry no last mark; a second last byte waits
// there, and req.ready drops only then. Reset (synchronous, active high)
// empties both registers, sets the recurrence terms to 1 and position to 0.
`default_nettype none

module three_term_recurrence_checksum_top import ttrc_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   ttrc_req_if.sink  req,
   ttrc_rsp_if.source rsp
);

   `include "three_term_recurrence_checksum_top_macros.svh"

   req_item_type     s1_ff, s1_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [TermW-1:0] older_ff, older_in;
   logic [TermW-1:0] newer_ff, newer_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [TermW-1:0] rsp_checksum_ff, rsp_checksum_in;

   logic             consume;
   logic             accept;
   logic [TermW-1:0] step_term;
   logic [TermW-1:0] start_term;

   // Handshake: the held byte leaves unless it is last and the output is held
   assign consume    = s1_valid_ff && (!s1_ff.last_byte || !rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || consume;
   assign accept     = req.valid && req.ready;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.checksum = rsp_checksum_ff;

   ttrc_step u_step (
      .data_byte  (s1_ff.data_byte),
      .position   (pos_ff),
      .older_term (older_ff),
      .newer_term (newer_ff),
      .next_term  (step_term)
   );

   assign start_term = TermW'(s1_ff.data_byte) + FirstOffset;

   // Input register
   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !consume);
      s1_in       = s1_ff;
      if (accept) begin
         s1_in.data_byte  = req.data_byte;
         s1_in.first_byte = req.first_byte;
         s1_in.last_byte  = req.last_byte;
      end
   end

   // Recurrence state
   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      pos_in   = pos_ff;
      if (consume) begin
         if (s1_ff.first_byte) begin
            older_in = TermOne;
            newer_in = start_term;
            pos_in   = PosOne;
         end else begin
            older_in = newer_ff;
            newer_in = step_term;
            pos_in   = pos_ff + PosOne;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_checksum_in = rsp_checksum_ff;
      if (consume && s1_ff.last_byte) begin
         rsp_valid_in    = 1'b1;
         rsp_checksum_in = newer_in;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         older_ff     <= TermOne;
         newer_ff     <= TermOne;
         pos_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         pos_ff       <= pos_in;
      end
      s1_ff           <= s1_in;
      rsp_checksum_ff <= rsp_checksum_in;
   end

   // Checks
   `TTRC_ASSERT_ALWAYS(a_terms_reduced, (older_ff != Modulus) && (newer_ff != Modulus), "recurrence term not reduced")
   `TTRC_ASSERT_ALWAYS(a_rsp_reduced, !rsp_valid_ff || (rsp_checksum_ff != Modulus), "checksum out of range")
   `TTRC_ASSERT_NEXT(a_first_restart, consume && s1_ff.first_byte, (pos_ff == PosOne) && (older_ff == TermOne), "first byte did not restart recurrence")
   `TTRC_ASSERT_NEXT(a_held_byte_kept, s1_valid_ff && !consume, s1_valid_ff && $stable(s1_ff), "held byte lost")
   `TTRC_ASSERT_NEXT(a_last_emits, consume && s1_ff.last_byte, rsp_valid_ff && (rsp_checksum_ff == newer_ff), "last byte gave no checksum")

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ttrc_pkg::*;

   // Per-position coefficient steps of the recurrence
   localparam int AlphaStep = 17;
   localparam int BetaStep  = 31;
   localparam int RandItems = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttrc_req_if req_ch ();
   ttrc_rsp_if rsp_ch ();

   three_term_recurrence_checksum_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted recurrence state
   logic [TermW-1:0] older_term_q = TermOne;
   logic [TermW-1:0] newer_term_q = TermOne;
   logic [PosW-1:0]  position_q   = '0;

   logic [TermW-1:0] checksum_expected[$];
   req_item_type     pending_bytes[$];
   req_item_type     next_item;
   req_item_type     seen_item;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  error_count    = 0;
   int  message_count  = 0;
   int  long_messages  = 0;
   int  borrow_steps   = 0;
   int  burst_left     = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  sink_cycle     = 0;
   bit  req_taken      = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Advance the predicted recurrence by one accepted item
   task automatic step_checksum(input req_item_type it);
      logic [7:0]      alpha;
      logic [7:0]      beta;
      longint unsigned prod;
      longint unsigned sub;
      longint unsigned fold;
      if (it.first_byte) begin
         older_term_q = TermOne;
         newer_term_q = TermW'(it.data_byte) + FirstOffset;
         position_q   = PosOne;
      end else begin
         alpha = 8'(int'(position_q) * AlphaStep);
         beta  = 8'(int'(position_q) * BetaStep);
         prod  = (64'(it.data_byte) + 64'(alpha)) * 64'(newer_term_q);
         sub   = 64'(beta) * 64'(older_term_q);
         // A negative difference wraps modulo 2^64, which is 1 modulo 65535
         if (prod >= sub) begin
            fold = (prod - sub) % 64'(Modulus);
         end else begin
            fold = (64'd65536 - ((sub - prod) % 64'(Modulus))) % 64'(Modulus);
            borrow_steps++;
         end
         older_term_q = newer_term_q;
         newer_term_q = TermW'(fold);
         position_q   = position_q + PosOne;
      end
      if (it.last_byte) checksum_expected.push_back(newer_term_q);
   endtask

   task automatic push_byte(input int data, input bit first, input bit last);
      req_item_type it;
      it.data_byte  = ByteW'(data);
      it.first_byte = first;
      it.last_byte  = last;
      pending_bytes.push_back(it);
      queued_count++;
   endtask

   // Well-formed message with random content; optionally left unterminated
   task automatic push_message(input int len, input bit terminated);
      for (int i = 0; i < len; i++) begin
         push_byte($urandom_range(0, 255), i == 0, terminated && (i == len - 1));
      end
      message_count++;
   endtask

   task automatic wait_for_drain();
      while (accepted_count != queued_count || checksum_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Sender: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left     <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            next_item = pending_bytes.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.data_byte  <= next_item.data_byte;
            req_ch.first_byte <= next_item.first_byte;
            req_ch.last_byte  <= next_item.last_byte;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: always ready, coin-flip ready, or long stalls, rotating by phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         sink_cycle <= sink_cycle + 1;
         if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((sink_cycle / 300) % 3)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: begin
                  if ($urandom_range(0, 15) == 0) begin
                     stall_left   <= $urandom_range(1, 20);
                     rsp_ch.ready <= 1'b0;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Monitor: predict on accepted input, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen_item.data_byte  = req_ch.data_byte;
            seen_item.first_byte = req_ch.first_byte;
            seen_item.last_byte  = req_ch.last_byte;
            step_checksum(seen_item);
            accepted_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (checksum_expected.size() == 0) begin
               report_mismatch("unexpected checksum item", rsp_ch.checksum, -1);
            end else begin
               if (rsp_ch.checksum !== checksum_expected[0]) begin
                  report_mismatch("checksum", rsp_ch.checksum, checksum_expected[0]);
               end
               void'(checksum_expected.pop_front());
               checked_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int  pick;
      int  len;
      bit  paused;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.first_byte = 1'b0;
      req_ch.last_byte  = 1'b0;
      rsp_ch.ready      = 1'b0;
      paused            = 1'b0;

      // Stray bytes straight after reset, before any first byte (position 0)
      push_byte(200, 1'b0, 1'b0);
      push_byte(255, 1'b0, 1'b1);
      // Single-byte messages at both data extremes
      push_byte(0, 1'b1, 1'b1);
      push_byte(255, 1'b1, 1'b1);
      // Short message of extreme bytes
      push_byte(255, 1'b1, 1'b0);
      push_byte(255, 1'b0, 1'b0);
      push_byte(0, 1'b0, 1'b0);
      push_byte(255, 1'b0, 1'b0);
      push_byte(0, 1'b0, 1'b1);
      // Bytes continuing after a finished message, no new first mark
      push_byte(128, 1'b0, 1'b0);
      push_byte(1, 1'b0, 1'b1);
      // Message restarted in the middle by a new first byte
      push_byte(10, 1'b1, 1'b0);
      push_byte(20, 1'b0, 1'b0);
      push_byte(30, 1'b1, 1'b0);
      push_byte(40, 1'b0, 1'b1);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_for_drain();

      // Random messages, mostly well formed, some noise and broken ones
      while (queued_count < RandItems + 15) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            len = $urandom_range(1, 6);
            repeat (len) push_byte($urandom_range(0, 255), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
         end else if (pick == 1 && long_messages < 3) begin
            // Long enough to wrap the position counter
            push_message($urandom_range(257, 300), 1'b1);
            long_messages++;
         end else if (pick == 2) begin
            push_message($urandom_range(1, 6), 1'b0);
         end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 40);
            push_message(len, 1'b1);
         end
         // Hold the sender once until every checksum is back
         if (!paused && queued_count > RandItems / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
      end

      wait_for_drain();
      repeat (10) @(negedge clock);

      $display("Sent %0d bytes in %0d messages (%0d long enough to wrap position).",
               accepted_count, message_count, long_messages);
      $display("Checked %0d checksums; %0d steps went through a negative difference.",
               checked_count, borrow_steps);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timeout: %0d of %0d bytes accepted, %0d checksums outstanding",
               accepted_count, queued_count, checksum_expected.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> three_term_recurrence_checksum_top.f
+incdir+rtl
rtl/ttrc_pkg.sv
rtl/ttrc_req_if.sv
rtl/ttrc_rsp_if.sv
rtl/ttrc_step.sv
rtl/three_term_recurrence_checksum_top.sv
test/tb.sv
